FILE: hw/rtl/hdf_pkg.sv
// shared types and constants for the chunked transfer deframer
package hdf_pkg;

    // deframing phases
    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_CR = 3'd1,
        PH_DATA    = 3'd2,
        PH_SKIP2   = 3'd3,
        PH_SKIP1   = 3'd4
    } phase_t;

    // line terminator characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // register indexes on the configuration port
    localparam logic REG_CHUNKED_MODE = 1'b0;

    // control from the top level to the step unit
    typedef struct packed {
        logic step;
        logic clear;
        logic chunked;
    } hdf_ctrl_t;

    // result flags from the step unit
    typedef struct packed {
        logic emit;
        logic last;
    } hdf_result_t;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // ascii hex character to nibble
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.ok    = 1'b0;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.ok    = 1'b1;
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.ok    = 1'b1;
            d.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.ok    = 1'b1;
            d.value = 4'(b - 8'h37);
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/hdf_step.sv
// per-byte deframing state machine: size line parse, payload count, skip
module hdf_step #(
    parameter int SIZE_BITS = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hdf_pkg::hdf_ctrl_t  ctrl,
    input  logic [7:0]          body_byte,
    output hdf_pkg::hdf_result_t result
);
    import hdf_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   remain_reg, remain_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic                   bad_reg, bad_next;

    hex_digit_t             digit;
    logic [SIZE_BITS-1:0]   remain_dec;
    logic [SIZE_BITS-1:0]   line_size;
    logic                   acc_full;
    logic                   char_bad;

    assign digit      = hex_decode(body_byte);
    assign remain_dec = remain_reg - SIZE_BITS'(1);
    assign acc_full   = (acc_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign line_size  = bad_reg ? '0 : acc_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIZE;
            remain_reg <= '0;
            acc_reg    <= '0;
            bad_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
            bad_reg    <= bad_next;
        end
    end

    // next state and result flags
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        acc_next    = acc_reg;
        bad_next    = bad_reg;
        result.emit = 1'b0;
        result.last = 1'b0;
        char_bad    = 1'b0;

        if (ctrl.clear) begin
            phase_next  = PH_SIZE;
            remain_next = '0;
            acc_next    = '0;
            bad_next    = 1'b0;
        end else if (ctrl.step && !ctrl.chunked) begin
            // pass-through leaves the deframing state alone
            result.emit = 1'b1;
        end else if (ctrl.step) begin
            case (phase_reg)
                PH_SIZE, PH_SIZE_CR: begin
                    if (phase_reg == PH_SIZE_CR && body_byte == CHAR_LF) begin
                        // end of size line
                        acc_next = '0;
                        bad_next = 1'b0;
                        if (line_size == '0) begin
                            remain_next = '0;
                            phase_next  = PH_SKIP2;
                        end else begin
                            remain_next = line_size;
                            phase_next  = PH_DATA;
                        end
                    end else begin
                        // a CR without LF marks the line bad
                        char_bad = (phase_reg == PH_SIZE_CR);
                        if (body_byte == CHAR_CR) begin
                            phase_next = PH_SIZE_CR;
                        end else begin
                            phase_next = PH_SIZE;
                            if (!digit.ok || acc_full) begin
                                char_bad = 1'b1;
                            end else begin
                                acc_next = {acc_reg[SIZE_BITS-5:0], digit.value};
                            end
                        end
                        bad_next = bad_reg | char_bad;
                    end
                end
                PH_DATA: begin
                    remain_next = remain_dec;
                    result.emit = 1'b1;
                    result.last = (remain_dec == '0);
                    if (remain_dec == '0) begin
                        phase_next = PH_SKIP2;
                    end
                end
                PH_SKIP2: begin
                    phase_next = PH_SKIP1;
                end
                PH_SKIP1: begin
                    phase_next = PH_SIZE;
                end
                default: begin
                    phase_next  = PH_SIZE;
                    remain_next = '0;
                    acc_next    = '0;
                    bad_next    = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/http_chunked_deframer.sv
// http/1.1 chunked transfer deframer top level
//
// s_ channel takes raw response body bytes (s_tdata), one per request.
// m_ channel gives decoded payload bytes (m_tdata) with m_tlast high on
// the last byte of each chunk; size lines and the CR LF after each chunk
// give no request on m_. An apb port holds chunked_mode at address 0:
// 0 passes every byte through, 1 decodes chunked encoding. Any write to
// it returns the deframer to the start of a size line.
// A byte passes an input register and the state update and lands in the
// output register. One byte per cycle is sustained: s_tready stays high
// while the output register is empty or being taken in the same cycle.
// When m_tready is low the output holds and the pipeline fills; s_tready
// drops once the input register holds a byte that cannot move on.
// Reset (aresetn low, synchronous) empties both registers, sets
// chunked_mode to 0 and puts the deframer at the start of a size line.
module http_chunked_deframer #(
    parameter int SIZE_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] body_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] payload_byte
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hdf_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        mode_reg;

    logic        out_free;
    logic        advance;
    logic        cfg_write;
    logic        mode_hit;
    hdf_ctrl_t   ctrl;
    hdf_result_t result;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign mode_hit  = (paddr[2] == REG_CHUNKED_MODE);
    assign prdata    = mode_hit ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_write && mode_hit) begin
            mode_reg <= pwdata[0];
        end
    end

    // pipeline handshake
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tvalid && s_tready ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? result.emit : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_byte_reg <= in_byte_reg;
            out_last_reg <= result.last;
        end
    end

    // deframing state update
    assign ctrl.step    = advance;
    assign ctrl.clear   = cfg_write && mode_hit;
    assign ctrl.chunked = mode_reg;

    hdf_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .body_byte (in_byte_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: verif/tb_http_chunked_deframer.sv
`timescale 1ns / 100ps
// self-checking bench for the chunked transfer deframer: a directed table, then random body streams
module tb_http_chunked_deframer;
    import hdf_pkg::*;

    localparam int SIZE_BITS    = 31;
    localparam int BODY_ITEMS   = 1650;
    localparam int GAP_PCT      = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DIR_ROWS     = 27;

    typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] val;
        logic       typed;
        payload_t   want;
    } dir_row_t;

    // directed stream: pass-through extremes, a one byte chunk, a lone CR,
    // the largest size that fits, then extreme payload bytes
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
        '{ROW_MODE, 8'h01, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h31, 1'b0, '{8'h00, 1'b0}},   // "1" CR LF
        '{ROW_BYTE, 8'h0D, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0A, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h41, 1'b1, '{8'h41, 1'b1}},   // only payload byte, ends chunk
        '{ROW_BYTE, 8'h0D, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0A, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0D, 1'b0, '{8'h00, 1'b0}},   // CR without LF spoils the line
        '{ROW_BYTE, 8'h66, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0D, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0A, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h78, 1'b0, '{8'h00, 1'b0}},   // two skipped bytes
        '{ROW_BYTE, 8'h79, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h37, 1'b0, '{8'h00, 1'b0}},   // "7FFFFFFF" CR LF
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h46, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0D, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h0A, 1'b0, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predicted deframer state
    logic                 mode_on;
    phase_t               line_phase;
    logic [SIZE_BITS-1:0] bytes_left;
    logic [SIZE_BITS-1:0] size_acc;
    logic                 line_bad;

    payload_t payload_q [$];
    int       err_count   = 0;
    int       bytes_sent  = 0;
    int       cycle_count = 0;
    bit       calm        = 1'b0;
    bit       stall_req   = 1'b0;

    http_chunked_deframer #(.SIZE_BITS(SIZE_BITS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ascii hex to {valid, value}, valid set means 16 or more
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void clear_deframer();
        line_phase = PH_SIZE;
        bytes_left = '0;
        size_acc   = '0;
        line_bad   = 1'b0;
    endfunction

    // size line byte other than the LF closing the line
    function automatic void take_line_char(input logic [7:0] b);
        logic [4:0] nib;
        nib = hex_nibble(b);
        if (b == CHAR_CR) begin
            line_phase = PH_SIZE_CR;
        end else begin
            line_phase = PH_SIZE;
            if (!nib[4])
                line_bad = 1'b1;
            else if (size_acc[SIZE_BITS-1 -: 4] != 4'd0)
                line_bad = 1'b1;
            else
                size_acc = {size_acc[SIZE_BITS-5:0], nib[3:0]};
        end
    endfunction

    // advance the predicted state by one body byte, 1 when a payload byte comes out
    function automatic logic deframe_byte(input logic [7:0] b, output payload_t res);
        logic [SIZE_BITS-1:0] size;
        res = '{b, 1'b0};
        if (!mode_on)
            return 1'b1;
        case (line_phase)
            PH_SIZE: begin
                take_line_char(b);
            end
            PH_SIZE_CR: begin
                if (b == CHAR_LF) begin
                    size       = line_bad ? '0 : size_acc;
                    size_acc   = '0;
                    line_bad   = 1'b0;
                    bytes_left = size;
                    line_phase = (size == '0) ? PH_SKIP2 : PH_DATA;
                end else begin
                    line_bad = 1'b1;
                    take_line_char(b);
                end
            end
            PH_DATA: begin
                bytes_left = bytes_left - 1'b1;
                res.last   = (bytes_left == '0);
                if (res.last)
                    line_phase = PH_SKIP2;
                return 1'b1;
            end
            PH_SKIP2: begin
                line_phase = PH_SKIP1;
            end
            PH_SKIP1: begin
                line_phase = PH_SIZE;
            end
            default: begin
                clear_deframer();
            end
        endcase
        return 1'b0;
    endfunction

    // offer one body byte and wait for the request to be taken
    task automatic send_body(input logic [7:0] b, input logic typed = 1'b0,
                             input payload_t want = '0);
        payload_t res;
        logic     got;
        got = deframe_byte(b, res);
        if (typed)
            payload_q.push_back(want);
        else if (got)
            payload_q.push_back(res);
        if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // let all outstanding payload come out, then wait for line bytes in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (payload_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write chunked_mode, then read it back
    task automatic set_chunked_mode(input logic on);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CHUNKED_MODE, 2'b00};
        pwdata  <= {31'($urandom), on};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        mode_on = on;
        clear_deframer();
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[0] !== on) begin
            $display("%0t: chunked_mode read expected %0b got %0b", $time, on, prdata[0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one chunk, mostly well formed, sometimes broken
    task automatic send_chunk();
        int         kind;
        int         r;
        int         size;
        logic [7:0] c;
        logic       upper;
        kind  = $urandom_range(0, 99);
        r     = $urandom_range(0, 99);
        size  = (r < 8) ? 0 : (r < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        upper = $urandom_range(0, 1);
        if (kind < 6) begin
            // size line too large for the counter
            if ($urandom_range(0, 1)) begin
                send_body(hex_char(4'($urandom_range(8, 15)), upper));
                repeat (7) send_body(hex_char(4'($urandom), upper));
            end else begin
                send_body(hex_char(4'($urandom_range(1, 15)), upper));
                repeat (8) send_body(hex_char(4'($urandom), upper));
            end
        end else if (kind >= 9) begin
            // digits of the size, sometimes with leading zeros
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_body(8'h30);
            if (size > 15)
                send_body(hex_char(4'(size >> 4), upper));
            send_body(hex_char(4'(size), upper));
            if (kind < 16) begin
                // stray non-hex character
                do c = 8'($urandom); while (hex_nibble(c) > 5'h0f || c == CHAR_CR);
                send_body(c);
            end else if (kind < 21) begin
                // lone CR inside the line
                send_body(CHAR_CR);
                send_body(hex_char(4'($urandom), upper));
            end
        end
        // line end, kinds 6 to 8 leave the line empty
        send_body(CHAR_CR);
        if (kind >= 21 && kind < 24) begin
            do c = 8'($urandom); while (c == CHAR_LF);
            send_body(c);
        end else begin
            send_body(CHAR_LF);
        end
        // payload for as long as the line asked
        while (line_phase == PH_DATA) send_body(8'($urandom));
        // trailing pair, normally CR LF
        if (line_phase == PH_SKIP2) begin
            if ($urandom_range(0, 9) != 0) begin
                send_body(CHAR_CR);
                send_body(CHAR_LF);
            end else begin
                repeat (2) send_body(8'($urandom));
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        int   phase_no;
        int   phase_end;
        int   dir_bytes;
        logic mode_sel;
        mode_on = 1'b0;
        clear_deframer();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_MODE) begin
                drain();
                set_chunked_mode(dir_tab[i].val[0]);
            end else begin
                send_body(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
            end
        end
        dir_bytes = bytes_sent;

        // random phases, each starting with a mode write
        phase_no = 0;
        while (bytes_sent < dir_bytes + BODY_ITEMS) begin
            drain();
            case (phase_no)
                0, 2: mode_sel = 1'b1;
                1, 3: mode_sel = 1'b0;
                default: mode_sel = $urandom_range(0, 1);
            endcase
            set_chunked_mode(mode_sel);
            calm = (phase_no == 2);
            if (phase_no == 3)
                stall_req = 1'b1;
            phase_end = bytes_sent + $urandom_range(60, 180);
            while (bytes_sent < phase_end) begin
                if (mode_sel)
                    send_chunk();
                else
                    send_body(8'($urandom));
            end
            phase_no++;
        end
        calm = 1'b0;
        drain();

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side readiness, with one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    // compare each payload request with the oldest prediction
    always @(posedge aclk) begin : payload_check
        payload_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (payload_q.size() == 0) begin
                $display("%0t: unexpected payload byte, expected none got %02h last %0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                want = payload_q.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: payload byte expected %02h got %02h",
                             $time, want.data, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: chunk end expected %0b got %0b",
                             $time, want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
